// File: rtl/vt52_escape_decoder_unit_macros.svh
// ----------------------------------------------------------------------------
// vt52 escape decoder assertion macros
// property checks for simulation, empty under synthesis
// ----------------------------------------------------------------------------
`ifndef VT52_ESCAPE_DECODER_UNIT_MACROS_SVH
`define VT52_ESCAPE_DECODER_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define VT52_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("vt52 decoder check failed");

// next-cycle implication
`define VT52_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("vt52 decoder check failed");

`else

`define VT52_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define VT52_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// File: rtl/vt52_pkg.sv
// ----------------------------------------------------------------------------
// vt52 escape decoder package
// parser states, action codes and the escape letter decode table
// ----------------------------------------------------------------------------
package vt52_pkg;

   localparam int unsigned ByteWidth   = 8;
   localparam int unsigned ActionWidth = 6;
   localparam int unsigned ArgWidth    = 9;

   typedef logic [ByteWidth-1:0]   byte_type;
   typedef logic [ActionWidth-1:0] action_type;
   typedef logic signed [ArgWidth-1:0] argument_type;

   typedef enum logic [2:0] {
      ST_GROUND = 3'd0,
      ST_ESCAPE = 3'd1,
      ST_ROW    = 3'd2,
      ST_COL    = 3'd3,
      ST_FG     = 3'd4,
      ST_BG     = 3'd5
   } parse_state_type;

   // special bytes
   localparam byte_type CHR_ESC      = 8'h1B;
   localparam byte_type CHR_CTRL_MAX = 8'h1F;
   localparam byte_type CHR_DEL      = 8'h7F;
   localparam byte_type CHR_SPACE    = 8'h20;
   localparam byte_type CHR_ROW_OPEN = 8'h59;
   localparam byte_type CHR_FG_OPEN  = 8'h62;
   localparam byte_type CHR_BG_OPEN  = 8'h63;

   // action codes
   localparam action_type ACT_NONE        = 6'd0;
   localparam action_type ACT_CONTROL     = 6'd1;
   localparam action_type ACT_PRINT       = 6'd2;
   localparam action_type ACT_ROW         = 6'd3;
   localparam action_type ACT_COL         = 6'd4;
   localparam action_type ACT_FG          = 6'd5;
   localparam action_type ACT_BG          = 6'd6;
   localparam action_type ACT_ANSI        = 6'd7;
   localparam action_type ACT_KPAD_ALT    = 6'd8;
   localparam action_type ACT_KPAD_NUM    = 6'd9;
   localparam action_type ACT_CUR_UP      = 6'd10;
   localparam action_type ACT_CUR_DOWN    = 6'd11;
   localparam action_type ACT_CUR_RIGHT   = 6'd12;
   localparam action_type ACT_CUR_LEFT    = 6'd13;
   localparam action_type ACT_CLEAR_HOME  = 6'd14;
   localparam action_type ACT_GFX_ON      = 6'd15;
   localparam action_type ACT_GFX_OFF     = 6'd16;
   localparam action_type ACT_HOME        = 6'd17;
   localparam action_type ACT_REV_INDEX   = 6'd18;
   localparam action_type ACT_ERASE_EOS   = 6'd19;
   localparam action_type ACT_ERASE_EOL   = 6'd20;
   localparam action_type ACT_INS_LINE    = 6'd21;
   localparam action_type ACT_DEL_LINE    = 6'd22;
   localparam action_type ACT_RESET       = 6'd23;
   localparam action_type ACT_REV_ON_T    = 6'd24;
   localparam action_type ACT_REV_OFF_U   = 6'd25;
   localparam action_type ACT_IDENTIFY    = 6'd26;
   localparam action_type ACT_ERASE_BOS   = 6'd27;
   localparam action_type ACT_CUR_SHOW    = 6'd28;
   localparam action_type ACT_CUR_HIDE    = 6'd29;
   localparam action_type ACT_CUR_SAVE    = 6'd30;
   localparam action_type ACT_CUR_RESTORE = 6'd31;
   localparam action_type ACT_ERASE_LINE  = 6'd32;
   localparam action_type ACT_ERASE_BOL   = 6'd33;
   localparam action_type ACT_REV_ON_P    = 6'd34;
   localparam action_type ACT_REV_OFF_Q   = 6'd35;
   localparam action_type ACT_WRAP_ON     = 6'd36;
   localparam action_type ACT_WRAP_OFF    = 6'd37;
   localparam action_type ACT_UNKNOWN     = 6'd38;

   // action for the byte after ESC; unsupported features and openers give none
   function automatic action_type escape_code(input byte_type b);
      action_type code;
      code = ACT_UNKNOWN;
      case (b) inside
         8'h3C: code = ACT_ANSI;
         8'h3D: code = ACT_KPAD_ALT;
         8'h3E: code = ACT_KPAD_NUM;
         8'h41: code = ACT_CUR_UP;
         8'h42: code = ACT_CUR_DOWN;
         8'h43: code = ACT_CUR_RIGHT;
         8'h44: code = ACT_CUR_LEFT;
         8'h45: code = ACT_CLEAR_HOME;
         8'h46: code = ACT_GFX_ON;
         8'h47: code = ACT_GFX_OFF;
         8'h48: code = ACT_HOME;
         8'h49: code = ACT_REV_INDEX;
         8'h4A: code = ACT_ERASE_EOS;
         8'h4B: code = ACT_ERASE_EOL;
         8'h4C: code = ACT_INS_LINE;
         8'h4D: code = ACT_DEL_LINE;
         8'h52: code = ACT_RESET;
         8'h54: code = ACT_REV_ON_T;
         8'h55: code = ACT_REV_OFF_U;
         8'h5A: code = ACT_IDENTIFY;
         8'h64: code = ACT_ERASE_BOS;
         8'h65: code = ACT_CUR_SHOW;
         8'h66: code = ACT_CUR_HIDE;
         8'h6A: code = ACT_CUR_SAVE;
         8'h6B: code = ACT_CUR_RESTORE;
         8'h6C: code = ACT_ERASE_LINE;
         8'h6F: code = ACT_ERASE_BOL;
         8'h70: code = ACT_REV_ON_P;
         8'h71: code = ACT_REV_OFF_Q;
         8'h76: code = ACT_WRAP_ON;
         8'h77: code = ACT_WRAP_OFF;
         8'h31, 8'h32, 8'h5B, 8'h5C, 8'h56, 8'h57, 8'h58, 8'h5D,
         8'h5E, 8'h5F, 8'h50, 8'h53, CHR_ROW_OPEN, CHR_FG_OPEN, CHR_BG_OPEN:
            code = ACT_NONE;
         default: code = ACT_UNKNOWN;
      endcase
      return code;
   endfunction

endpackage

// File: rtl/vt52_escape_decoder_unit.sv
// ----------------------------------------------------------------------------
// vt52 escape decoder unit
// byte-serial escape sequence parser, one action beat out per byte beat in
// ----------------------------------------------------------------------------
//
//  channel | direction | ports                               | beat
//  --------+-----------+-------------------------------------+----------------------
//  req     | in        | req_valid, req_stall, req_in_byte   | one terminal byte
//  rsp     | out       | rsp_valid, rsp_stall, rsp_action,   | one decoded action
//          |           | rsp_argument                        |
//
//  a byte beat is registered in the input register and is then decoded into the
//  result register; a new beat can be taken every cycle while the result is not
//  stalled; the parse state register closes the only loop
//  reset (synchronous, active high) empties both stages and returns to ground
//  a stalled result holds the result register; the input register then fills
//  and req_stall rises only while both stages are occupied
//
`include "vt52_escape_decoder_unit_macros.svh"

module vt52_escape_decoder_unit (
   input  logic                  clock,
   input  logic                  reset,
   // byte input
   input  logic                  req_valid,
   output logic                  req_stall,
   input  vt52_pkg::byte_type    req_in_byte,
   // action output
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output vt52_pkg::action_type  rsp_action,
   output vt52_pkg::argument_type rsp_argument
);
   import vt52_pkg::*;

   // input register stage
   logic            in_valid_ff;
   byte_type        in_byte_ff;

   // parser state
   parse_state_type state_ff;
   parse_state_type state_in;

   // result register stage
   logic            out_valid_ff;
   action_type      action_ff;
   argument_type    argument_ff;

   // decode outputs
   action_type      action_in;
   argument_type    argument_in;

   logic            req_take;
   logic            decode_go;

   // decode fires when the result register is free or being emptied
   assign decode_go = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !decode_go;
   assign req_take  = req_valid && !req_stall;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_take) begin
         in_valid_ff <= 1'b1;
      end else if (decode_go) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_in_byte;
      end
   end

   // next parser state
   always_comb begin
      state_in = ST_GROUND;
      unique case (state_ff)
         ST_ESCAPE: begin
            if (in_byte_ff == CHR_ROW_OPEN) begin
               state_in = ST_ROW;
            end else if (in_byte_ff == CHR_FG_OPEN) begin
               state_in = ST_FG;
            end else if (in_byte_ff == CHR_BG_OPEN) begin
               state_in = ST_BG;
            end else begin
               state_in = ST_GROUND;
            end
         end
         ST_ROW: begin
            state_in = ST_COL;
         end
         ST_COL, ST_FG, ST_BG: begin
            state_in = ST_GROUND;
         end
         default: begin
            // ground, and any unused code, opens an escape on ESC only
            state_in = (in_byte_ff == CHR_ESC) ? ST_ESCAPE : ST_GROUND;
         end
      endcase
   end

   // action and argument for the byte in the input register
   always_comb begin
      action_in   = ACT_NONE;
      argument_in = '0;
      unique case (state_ff)
         ST_ESCAPE: begin
            action_in = escape_code(in_byte_ff);
            if (action_in == ACT_UNKNOWN) begin
               argument_in = argument_type'({1'b0, in_byte_ff});
            end
         end
         ST_ROW: begin
            // cursor operands are biased by a space, may go negative
            action_in   = ACT_ROW;
            argument_in = argument_type'({1'b0, in_byte_ff} - {1'b0, CHR_SPACE});
         end
         ST_COL: begin
            action_in   = ACT_COL;
            argument_in = argument_type'({1'b0, in_byte_ff} - {1'b0, CHR_SPACE});
         end
         ST_FG: begin
            action_in   = ACT_FG;
            argument_in = argument_type'({5'b0, in_byte_ff[3:0]});
         end
         ST_BG: begin
            action_in   = ACT_BG;
            argument_in = argument_type'({5'b0, in_byte_ff[3:0]});
         end
         default: begin
            if (in_byte_ff == CHR_ESC) begin
               action_in = ACT_NONE;
            end else if (in_byte_ff <= CHR_CTRL_MAX || in_byte_ff == CHR_DEL) begin
               action_in   = ACT_CONTROL;
               argument_in = argument_type'({1'b0, in_byte_ff});
            end else begin
               action_in   = ACT_PRINT;
               argument_in = argument_type'({1'b0, in_byte_ff});
            end
         end
      endcase
   end

   // parser state advances once per decoded beat
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_GROUND;
      end else if (decode_go) begin
         state_ff <= state_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (decode_go) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (decode_go) begin
         action_ff   <= action_in;
         argument_ff <= argument_in;
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_action   = action_ff;
   assign rsp_argument = argument_ff;

   // ---------------------------------------------------------------------
   // checks
   // ---------------------------------------------------------------------

   // a byte that could not be decoded stays put for the next cycle
   `VT52_ASSERT_NEXT(a_held_byte, clock, reset, in_valid_ff && !decode_go, in_valid_ff && $stable(in_byte_ff))

   // every decode lands a result beat
   `VT52_ASSERT_NEXT(a_decode_lands, clock, reset, decode_go, rsp_valid)

   // the row operand is always followed by the column operand
   `VT52_ASSERT_NEXT(a_row_then_col, clock, reset, decode_go && state_ff == ST_ROW, state_ff == ST_COL)

   // colour arguments carry a nibble only
   `VT52_ASSERT_IMPLY(a_colour_nibble, clock, reset, rsp_valid && (rsp_action == ACT_FG || rsp_action == ACT_BG), rsp_argument[8:4] == 5'b0)

endmodule
